// ===== rtl/core/pls_pkg.sv =====
// shared constants and types for the positional list store
`default_nettype none

package pls_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;
    localparam int CNT_W = 5;
    localparam int PCW   = ((POS_W > CW) ? POS_W : CW) + 1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_END   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd6;

    typedef enum logic [ST_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_INS_CHK = 12'b0000_0000_0010,
        ST_INS_RD  = 12'b0000_0000_0100,
        ST_INS_WR  = 12'b0000_0000_1000,
        ST_DEL_RD  = 12'b0000_0001_0000,
        ST_DEL_CAP = 12'b0000_0010_0000,
        ST_DEL_CHK = 12'b0000_0100_0000,
        ST_SH_RD   = 12'b0000_1000_0000,
        ST_SH_WR   = 12'b0001_0000_0000,
        ST_SR_RD   = 12'b0010_0000_0000,
        ST_SR_CMP  = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/positional_list_store_unit.sv =====
// positional list store: ordered list in a slot ram, shifted one element at a time
// insert: check, read, write per element moved toward the end; the last check writes the value
// delete: read, capture, then check, read, write per element moved toward the front
// search: read, compare per element until a hit or the end; rejected commands skip to the result
// one word at a time; the single ram read port sets the pace of every move and compare
// reset clears the count and handshake state only; the slot ram is not cleared
`default_nettype none

module positional_list_store_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pls_pkg::S_TDATA_W-1:0]  s_tdata,  // cmd, value, position
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [pls_pkg::M_TDATA_W-1:0]  m_tdata   // status, found, removed_value, entry_count
);

    pls_pkg::state_t state_reg, state_next;

    logic [pls_pkg::CW-1:0]    occ_reg, occ_next;
    logic [pls_pkg::AW-1:0]    ptr_reg, ptr_next;
    logic [pls_pkg::AW-1:0]    idx_reg, idx_next;
    logic [pls_pkg::VAL_W-1:0] val_reg, val_next;
    pls_pkg::status_t          status_reg, status_next;
    logic                      found_reg, found_next;
    logic [pls_pkg::VAL_W-1:0] removed_reg, removed_next;

    logic                      m_tvalid_reg, m_tvalid_next;
    pls_pkg::status_t          out_status_reg, out_status_next;
    logic                      out_found_reg, out_found_next;
    logic [pls_pkg::VAL_W-1:0] out_removed_reg, out_removed_next;
    logic [pls_pkg::CNT_W-1:0] out_count_reg, out_count_next;

    logic [pls_pkg::CMD_W-1:0] in_cmd;
    logic [pls_pkg::VAL_W-1:0] in_val;
    logic [pls_pkg::POS_W-1:0] in_pos;
    logic [pls_pkg::PCW-1:0]   pos_w, occ_w, pos_m1;
    logic                      full, empty, ins_pos_ok, del_pos_ok, s_accept;
    logic [pls_pkg::CW-1:0]    ptr_inc_w;
    logic                      ptr_at_last;

    logic                      ram_we;
    logic [pls_pkg::AW-1:0]    ram_waddr, ram_raddr;
    logic [pls_pkg::VAL_W-1:0] ram_wdata, ram_rdata;

    pls_ram #(
        .WIDTH (pls_pkg::VAL_W),
        .DEPTH (pls_pkg::DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_cmd = s_tdata[2:0];
    assign in_val = s_tdata[34:3];
    assign in_pos = s_tdata[39:35];

    assign s_tready = (state_reg == pls_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign full       = (occ_reg == pls_pkg::CW'(pls_pkg::DEPTH));
    assign empty      = (occ_reg == '0);
    assign pos_w      = pls_pkg::PCW'(in_pos);
    assign occ_w      = pls_pkg::PCW'(occ_reg);
    assign pos_m1     = pos_w - pls_pkg::PCW'(1);
    assign ins_pos_ok = (pos_w != '0) && (pos_w <= occ_w + pls_pkg::PCW'(1));
    assign del_pos_ok = (pos_w != '0) && (pos_w <= occ_w);

    // shared address adder and end-of-list compare
    assign ptr_inc_w   = pls_pkg::CW'(ptr_reg) + pls_pkg::CW'(1);
    assign ptr_at_last = (ptr_inc_w >= occ_reg);

    always_comb begin
        state_next       = state_reg;
        occ_next         = occ_reg;
        ptr_next         = ptr_reg;
        idx_next         = idx_reg;
        val_next         = val_reg;
        status_next      = status_reg;
        found_next       = found_reg;
        removed_next     = removed_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = ptr_reg;
        ram_wdata        = ram_rdata;
        ram_raddr        = ptr_reg;

        case (state_reg)
            pls_pkg::ST_IDLE: begin
                if (s_accept) begin
                    val_next     = in_val;
                    found_next   = 1'b0;
                    removed_next = '0;
                    status_next  = pls_pkg::STAT_OK;
                    state_next   = pls_pkg::ST_DONE;
                    case (in_cmd)
                        pls_pkg::CMD_INS_FRONT, pls_pkg::CMD_INS_END,
                        pls_pkg::CMD_INS_POS: begin
                            if (full) begin
                                status_next = pls_pkg::STAT_FULL;
                            end else if (in_cmd == pls_pkg::CMD_INS_POS && !ins_pos_ok) begin
                                status_next = pls_pkg::STAT_RANGE;
                            end else begin
                                ptr_next = pls_pkg::AW'(occ_reg);
                                if (in_cmd == pls_pkg::CMD_INS_FRONT) begin
                                    idx_next = '0;
                                end else if (in_cmd == pls_pkg::CMD_INS_END) begin
                                    idx_next = pls_pkg::AW'(occ_reg);
                                end else begin
                                    idx_next = pls_pkg::AW'(pos_m1);
                                end
                                state_next = pls_pkg::ST_INS_CHK;
                            end
                        end
                        pls_pkg::CMD_DEL_FRONT, pls_pkg::CMD_DEL_END,
                        pls_pkg::CMD_DEL_POS: begin
                            if (empty) begin
                                status_next = pls_pkg::STAT_EMPTY;
                            end else if (in_cmd == pls_pkg::CMD_DEL_POS && !del_pos_ok) begin
                                status_next = pls_pkg::STAT_RANGE;
                            end else begin
                                if (in_cmd == pls_pkg::CMD_DEL_FRONT) begin
                                    idx_next = '0;
                                end else if (in_cmd == pls_pkg::CMD_DEL_END) begin
                                    idx_next = pls_pkg::AW'(occ_reg - pls_pkg::CW'(1));
                                end else begin
                                    idx_next = pls_pkg::AW'(pos_m1);
                                end
                                state_next = pls_pkg::ST_DEL_RD;
                            end
                        end
                        pls_pkg::CMD_SEARCH: begin
                            if (empty) begin
                                status_next = pls_pkg::STAT_EMPTY;
                            end else begin
                                ptr_next   = '0;
                                state_next = pls_pkg::ST_SR_RD;
                            end
                        end
                        default: begin
                            state_next = pls_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            pls_pkg::ST_INS_CHK: begin
                if (ptr_reg == idx_reg) begin
                    ram_we     = 1'b1;
                    ram_wdata  = val_reg;
                    occ_next   = occ_reg + pls_pkg::CW'(1);
                    state_next = pls_pkg::ST_DONE;
                end else begin
                    state_next = pls_pkg::ST_INS_RD;
                end
            end
            pls_pkg::ST_INS_RD: begin
                ram_raddr  = ptr_reg - pls_pkg::AW'(1);
                state_next = pls_pkg::ST_INS_WR;
            end
            pls_pkg::ST_INS_WR: begin
                ram_we     = 1'b1;
                ptr_next   = ptr_reg - pls_pkg::AW'(1);
                state_next = pls_pkg::ST_INS_CHK;
            end
            pls_pkg::ST_DEL_RD: begin
                ram_raddr  = idx_reg;
                state_next = pls_pkg::ST_DEL_CAP;
            end
            pls_pkg::ST_DEL_CAP: begin
                removed_next = ram_rdata;
                ptr_next     = idx_reg;
                state_next   = pls_pkg::ST_DEL_CHK;
            end
            pls_pkg::ST_DEL_CHK: begin
                if (ptr_at_last) begin
                    occ_next   = occ_reg - pls_pkg::CW'(1);
                    state_next = pls_pkg::ST_DONE;
                end else begin
                    state_next = pls_pkg::ST_SH_RD;
                end
            end
            pls_pkg::ST_SH_RD: begin
                ram_raddr  = pls_pkg::AW'(ptr_inc_w);
                state_next = pls_pkg::ST_SH_WR;
            end
            pls_pkg::ST_SH_WR: begin
                ram_we     = 1'b1;
                ptr_next   = pls_pkg::AW'(ptr_inc_w);
                state_next = pls_pkg::ST_DEL_CHK;
            end
            pls_pkg::ST_SR_RD: begin
                state_next = pls_pkg::ST_SR_CMP;
            end
            pls_pkg::ST_SR_CMP: begin
                if (ram_rdata == val_reg) begin
                    found_next = 1'b1;
                    state_next = pls_pkg::ST_DONE;
                end else if (ptr_at_last) begin
                    state_next = pls_pkg::ST_DONE;
                end else begin
                    ptr_next   = pls_pkg::AW'(ptr_inc_w);
                    state_next = pls_pkg::ST_SR_RD;
                end
            end
            pls_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next    = 1'b1;
                    out_status_next  = status_reg;
                    out_found_next   = found_reg;
                    out_removed_next = removed_reg;
                    out_count_next   = pls_pkg::CNT_W'(occ_reg);
                    state_next       = pls_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pls_pkg::ST_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg         <= ptr_next;
        idx_reg         <= idx_next;
        val_reg         <= val_next;
        status_reg      <= status_next;
        found_reg       <= found_next;
        removed_reg     <= removed_next;
        out_status_reg  <= out_status_next;
        out_found_reg   <= out_found_next;
        out_removed_reg <= out_removed_next;
        out_count_reg   <= out_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_count_reg, out_removed_reg, out_found_reg, out_status_reg};

    // count never exceeds the slot count
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= pls_pkg::CW'(pls_pkg::DEPTH))
        else $error("occupancy above depth");

    // a full report only comes with a full list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_status_reg == pls_pkg::STAT_FULL
        |-> out_count_reg == pls_pkg::CNT_W'(pls_pkg::DEPTH))
        else $error("full status with list not full");

    // an empty report only comes with an empty list
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_status_reg == pls_pkg::STAT_EMPTY |-> out_count_reg == '0)
        else $error("empty status with list not empty");

    // a hit only on a successful search
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_found_reg |-> out_status_reg == pls_pkg::STAT_OK)
        else $error("found flag with failing status");

    // count only moves while a command is in work
    a_occ_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pls_pkg::ST_IDLE |=> $stable(occ_reg) || !$past(aresetn))
        else $error("occupancy changed while idle");

endmodule

`default_nettype wire

// ===== rtl/core/pls_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
